// ===== sv/b91_pkg.sv =====
package b91_pkg;

	// Bit queue geometry and basE91 constants.
	localparam int QUEUE_W     = 13;
	localparam int COUNT_W     = 4;
	localparam int WIDE_W      = 14;
	localparam int SHORT_TAKE  = 13;
	localparam int LONG_TAKE   = 14;
	localparam int WIDE_LIMIT  = 88;
	localparam int RADIX       = 91;
	localparam int ONE_CHAR_MAX = 90;
	localparam int SHORT_FLUSH_BITS = 7;

	// Reciprocal of the radix, scaled by two to the RECIP_SHIFT, rounded down.
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP       = (1 << RECIP_SHIFT) / RADIX;
	localparam int PROD_W      = 26;
	localparam int QUOT_W      = 8;

	// One input beat: a message byte and its end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	// One output beat: an alphabet character and its end marks.
	typedef struct packed {
		logic [6:0] out_char;
		logic       run_end;
		logic       message_end;
	} out_beat_t;

	// Standard basE91 alphabet: letters, digits, then punctuation.
	function automatic logic [6:0] b91_char(input logic [6:0] idx);
		logic [6:0] c;
		c = 7'd65;
		if (idx < 7'd26) begin
			c = idx + 7'd65;
		end else if (idx < 7'd52) begin
			c = idx + 7'd71;
		end else if (idx < 7'd62) begin
			c = idx - 7'd4;
		end else begin
			case (idx)
				7'd62: c = 7'd33;
				7'd63: c = 7'd35;
				7'd64: c = 7'd36;
				7'd65: c = 7'd37;
				7'd66: c = 7'd38;
				7'd67: c = 7'd40;
				7'd68: c = 7'd41;
				7'd69: c = 7'd42;
				7'd70: c = 7'd43;
				7'd71: c = 7'd44;
				7'd72: c = 7'd46;
				7'd73: c = 7'd47;
				7'd74: c = 7'd58;
				7'd75: c = 7'd59;
				7'd76: c = 7'd60;
				7'd77: c = 7'd61;
				7'd78: c = 7'd62;
				7'd79: c = 7'd63;
				7'd80: c = 7'd64;
				7'd81: c = 7'd91;
				7'd82: c = 7'd93;
				7'd83: c = 7'd94;
				7'd84: c = 7'd95;
				7'd85: c = 7'd96;
				7'd86: c = 7'd123;
				7'd87: c = 7'd124;
				7'd88: c = 7'd125;
				7'd89: c = 7'd126;
				7'd90: c = 7'd34;
				default: c = 7'd65;
			endcase
		end
		return c;
	endfunction

endpackage

// ===== sv/base91_stream_encoder.sv =====
// The first character of a byte passes through the character buffer and then the output register to char_beat.
// Throughput: one character per cycle on the output while char_stall is low; a byte yields
// zero to four characters (about 1.23 on average), and a new byte is taken as the last one is sent.
// The character buffer holds one byte's characters and the single divide-by-91 step in the output path sends them.
// Reset (arst_n low) empties the bit queue, the character buffer and the output register.
module base91_stream_encoder
	import b91_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_beat,
	output logic      char_valid,
	input  logic      char_stall,
	output out_beat_t char_beat
);

	// Bit queue state.
	logic [QUEUE_W-1:0] queue_q;
	logic [COUNT_W-1:0] count_q;

	// Character buffer for the byte in progress.
	logic                 valid_s1;
	logic [WIDE_W-1:0]    val_s1;
	logic [QUEUE_W-1:0]   fq_s1;
	logic [QUOT_W-1:0]    vq_s1;
	logic [QUOT_W-1:0]    fqq_s1;
	logic                 pair_s1;
	logic [2:0]           cnt_s1;
	logic                 last_s1;
	logic [1:0]           pos_s1;

	// Input side: append the byte and decide what leaves the queue.
	logic [20:0]          qw;
	logic [4:0]           nw;
	logic                 take;
	logic                 wide;
	logic [WIDE_W-1:0]    val;
	logic [20:0]          rest;
	logic [QUEUE_W-1:0]   fq;
	logic [4:0]           nr;
	logic                 flush1;
	logic                 flush2;
	logic [2:0]           cnt;
	logic [PROD_W-1:0]    val_prod;
	logic [PROD_W-1:0]    fq_prod;
	logic                 accept;

	always_comb begin
		qw     = {8'd0, queue_q} | (21'(byte_beat.data_byte) << count_q);
		nw     = 5'(count_q) + 5'd8;
		take   = nw > 5'(SHORT_TAKE);
		wide   = qw[QUEUE_W-1:0] <= QUEUE_W'(WIDE_LIMIT);
		val    = wide ? qw[WIDE_W-1:0] : {1'b0, qw[QUEUE_W-1:0]};
		if (!take) begin
			rest = qw;
			nr   = nw;
		end else if (wide) begin
			rest = qw >> LONG_TAKE;
			nr   = nw - 5'(LONG_TAKE);
		end else begin
			rest = qw >> SHORT_TAKE;
			nr   = nw - 5'(SHORT_TAKE);
		end
		fq     = rest[QUEUE_W-1:0];
		flush1 = byte_beat.last_byte && (nr != 5'd0);
		flush2 = flush1 && ((nr > 5'(SHORT_FLUSH_BITS)) || (fq > QUEUE_W'(ONE_CHAR_MAX)));
		cnt    = (take ? 3'd2 : 3'd0) + 3'(flush1) + 3'(flush2);
		val_prod = PROD_W'(val) * PROD_W'(RECIP);
		fq_prod  = PROD_W'(fq) * PROD_W'(RECIP);
	end

	// Output side: pick the operand of the current character and finish the division.
	logic                 pair_sel;
	logic [WIDE_W-1:0]    op;
	logic [QUOT_W-1:0]    qe;
	logic [WIDE_W-1:0]    back;
	logic [QUOT_W-1:0]    rem_e;
	logic                 fix;
	logic [6:0]           rem;
	logic [QUOT_W-1:0]    quot;
	logic [6:0]           qmod;
	logic [6:0]           idx;
	logic                 final_char;
	logic                 out_free;
	logic                 fire;

	always_comb begin
		pair_sel   = pair_s1 && !pos_s1[1];
		op         = pair_sel ? val_s1 : {1'b0, fq_s1};
		qe         = pair_sel ? vq_s1 : fqq_s1;
		back       = WIDE_W'(qe) * WIDE_W'(RADIX);
		rem_e      = QUOT_W'(op - back);
		fix        = rem_e >= QUOT_W'(RADIX);
		rem        = fix ? 7'(rem_e - QUOT_W'(RADIX)) : 7'(rem_e);
		quot       = qe + QUOT_W'(fix);
		qmod       = (quot >= QUOT_W'(RADIX)) ? 7'(quot - QUOT_W'(RADIX)) : 7'(quot);
		idx        = pos_s1[0] ? qmod : rem;
		final_char = (3'(pos_s1) + 3'd1) == cnt_s1;
	end

	// Handshake: a new byte enters as the buffer hands over its final character.
	assign out_free   = !char_valid || !char_stall;
	assign fire       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !(fire && final_char);
	assign accept     = byte_valid && !byte_stall;

	// Bit queue update on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (byte_beat.last_byte) begin
				queue_q <= '0;
				count_q <= '0;
			end else begin
				queue_q <= fq;
				count_q <= COUNT_W'(nr);
			end
		end
	end

	// Character buffer: load on accept, step through the characters as they leave.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= cnt != 3'd0;
			pos_s1   <= '0;
		end else if (fire) begin
			if (final_char) begin
				valid_s1 <= 1'b0;
			end
			pos_s1 <= pos_s1 + 2'd1;
		end
	end

	// Buffer payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1  <= val;
			fq_s1   <= fq;
			vq_s1   <= val_prod[RECIP_SHIFT +: QUOT_W];
			fqq_s1  <= fq_prod[RECIP_SHIFT +: QUOT_W];
			pair_s1 <= take;
			cnt_s1  <= cnt;
			last_s1 <= byte_beat.last_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (out_free) begin
			char_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_beat.out_char    <= b91_char(idx);
			char_beat.run_end     <= final_char;
			char_beat.message_end <= final_char && last_s1;
		end
	end

	// The queue never holds more bits than its width.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SHORT_TAKE))
		else $error("bit count above queue width");

	// A loaded buffer always has a character left to send.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((3'(pos_s1) < cnt_s1) && (cnt_s1 <= 3'd4)))
		else $error("buffer position outside its character count");

	// The message end mark only comes on the final character of a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (!char_beat.message_end || char_beat.run_end))
		else $error("message end without run end");

	// The division correction leaves a remainder below the radix.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (rem < 7'(RADIX)) && (quot <= QUOT_W'(2 * RADIX - 2)))
		else $error("divide by radix out of range");

	// After a last byte is accepted, the queue is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_beat.last_byte) |=> (count_q == '0))
		else $error("queue not cleared after last byte");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import b91_pkg::*;

	// Cycles with no beat on either channel before the run is abandoned.
	localparam int STUCK_LIMIT = 2000;

	// Standard basE91 alphabet, index 0 in the leftmost byte.
	localparam logic [8*91-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&()*+,./:;<=>?@[]^_`{|}~\"";

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_beat_t  byte_beat = '0;
	logic      char_valid;
	logic      char_stall = 1'b0;
	out_beat_t char_beat;

	// Bytes waiting to be sent, and whether each must wait for the output to drain.
	in_beat_t  pending_bytes[$];
	bit        pending_holds[$];
	// Characters the encoder owes, oldest first.
	out_beat_t chars_due[$];

	// Encoder state as predicted.
	logic [QUEUE_W-1:0] held_bits = '0;
	logic [COUNT_W-1:0] held_count = '0;

	int   bytes_taken = 0;
	int   errors = 0;
	int   quiet_cycles = 0;
	logic calm;

	base91_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

	always #4 clk = ~clk;

	// A window of the run with no random gaps on the byte side and no stalls on the character side.
	assign calm = (bytes_taken >= 120) && (bytes_taken < 200);

	function automatic logic [6:0] alphabet_char(input int unsigned idx);
		return ALPHABET[8*(RADIX-1-(idx % RADIX)) +: 7];
	endfunction

	// Shift one byte into the predicted bit queue and queue the characters it yields.
	task automatic encode_byte(input in_beat_t b);
		int unsigned acc;
		int unsigned cnt;
		int unsigned val;
		int unsigned idx_list[$];
		out_beat_t   ch;
		cnt = 32'(held_count);
		acc = 32'(held_bits) | (32'(b.data_byte) << cnt);
		cnt += 8;
		if (cnt > SHORT_TAKE) begin
			val = acc & ((1 << SHORT_TAKE) - 1);
			if (val > WIDE_LIMIT) begin
				acc >>= SHORT_TAKE;
				cnt -= SHORT_TAKE;
			end else begin
				val = acc & ((1 << LONG_TAKE) - 1);
				acc >>= LONG_TAKE;
				cnt -= LONG_TAKE;
			end
			idx_list.insert(idx_list.size(), val % RADIX);
			idx_list.insert(idx_list.size(), val / RADIX);
		end
		// On the final byte, flush what remains and start the next message empty.
		if (b.last_byte) begin
			if (cnt != 0) begin
				idx_list.insert(idx_list.size(), acc % RADIX);
				if (cnt > SHORT_FLUSH_BITS || acc > ONE_CHAR_MAX) begin
					idx_list.insert(idx_list.size(), acc / RADIX);
				end
			end
			acc = 0;
			cnt = 0;
		end
		held_bits = acc[QUEUE_W-1:0];
		held_count = cnt[COUNT_W-1:0];
		foreach (idx_list[i]) begin
			ch.out_char = alphabet_char(idx_list[i]);
			ch.run_end = (i == idx_list.size() - 1);
			ch.message_end = b.last_byte && (i == idx_list.size() - 1);
			chars_due.insert(chars_due.size(), ch);
		end
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic last, input bit hold);
		in_beat_t b;
		b.data_byte = data;
		b.last_byte = last;
		pending_bytes.insert(pending_bytes.size(), b);
		pending_holds.insert(pending_holds.size(), hold);
	endtask

	// Byte driver: holds a beat until it is taken, then offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin : feed_bytes
		logic busy;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_beat <= '0;
		end else begin
			busy = byte_valid;
			if (byte_valid && !byte_stall) begin
				encode_byte(byte_beat);
				void'(pending_bytes.pop_front());
				void'(pending_holds.pop_front());
				bytes_taken <= bytes_taken + 1;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_bytes.size() > 0 && (!pending_holds[0] || chars_due.size() == 0)
						&& (calm || $urandom_range(0, 99) >= 15)) begin
					byte_valid <= 1'b1;
					byte_beat <= pending_bytes[0];
				end else begin
					byte_valid <= 1'b0;
					byte_beat <= in_beat_t'($urandom);
				end
			end
		end
	end

	// Character monitor: checks each beat against the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin : check_chars
		out_beat_t want;
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				if (chars_due.size() == 0) begin
					$error("unexpected character: out_char %0d", char_beat.out_char);
					errors++;
				end else begin
					want = chars_due.pop_front();
					if (char_beat.out_char !== want.out_char) begin
						$error("out_char: expected %0d, got %0d", want.out_char,
							char_beat.out_char);
						errors++;
					end
					if (char_beat.run_end !== want.run_end) begin
						$error("run_end: expected %0d, got %0d", want.run_end,
							char_beat.run_end);
						errors++;
					end
					if (char_beat.message_end !== want.message_end) begin
						$error("message_end: expected %0d, got %0d", want.message_end,
							char_beat.message_end);
						errors++;
					end
				end
			end
			char_stall <= !calm && ($urandom_range(0, 99) < 15);
		end
	end

	// Watchdog: too long without any beat means the encoder is stuck.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int len;
		int pick;
		logic [7:0] data;
		// Single-byte messages at both extremes.
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		// A 13-bit take followed by a one-character flush.
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		// Zero bytes force 14-bit takes; the last one leaves six bits, flushed as one character.
		for (int i = 0; i < 6; i++) begin
			queue_byte(8'h00, i == 5, i == 0);
		end
		// Seven bits left holding a value above 90, so the flush needs two characters.
		for (int i = 0; i < 9; i++) begin
			queue_byte(8'hFF, i == 8, 1'b0);
		end
		// Random messages; zero bytes are favored so that 14-bit takes show up often.
		while (pending_bytes.size() < 320) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					data = 8'h00;
				end else if (pick == 2) begin
					data = 8'hFF;
				end else begin
					data = 8'($urandom_range(0, 255));
				end
				queue_byte(data, i == len - 1,
					i == 0 && (pending_bytes.size() == 150 || $urandom_range(0, 29) == 0));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_bytes.size() != 0 || chars_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (errors == 0 && chars_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/b91_pkg.sv
sv/base91_stream_encoder.sv
tb/testbench.sv
